[design/rbm_pkg.sv]
// Shared widths, types and recoding function for the radix-16 Booth multiplier.
`timescale 1ns / 1ps
`default_nettype none

package rbm_pkg;

  localparam int A_WIDTH    = 32;
  localparam int B_WIDTH    = 32;
  localparam int IN_WIDTH   = 32;
  localparam int PROD_WIDTH = 64;
  localparam int DIGITS     = (B_WIDTH + 3) / 4;
  localparam int EXT_WIDTH  = DIGITS * 4;
  localparam int MULT_WIDTH = A_WIDTH + 4;
  localparam int NUM_MULTS  = 9;

  typedef struct packed {
    logic       neg;
    logic [3:0] mag;
  } digit_t;

  typedef digit_t [DIGITS-1:0] digit_vec_t;

  typedef logic signed [MULT_WIDTH-1:0] mult_t;
  typedef mult_t [NUM_MULTS-1:0] mult_set_t;

  function automatic digit_t booth_recode(input logic [4:0] window);
    logic [4:0] folded;
    logic [4:0] rounded;
    digit_t     d;
    folded  = window[4] ? (window ^ 5'h1F) : window;
    rounded = folded + 5'd1;
    d.neg   = window[4];
    d.mag   = rounded[4:1];
    return d;
  endfunction

endpackage

`default_nettype wire

[design/rbm_multiples.sv]
// Forms the multiples 0x to 8x of the multiplicand by shifts, adds and a subtraction.
`timescale 1ns / 1ps
`default_nettype none

module rbm_multiples
  import rbm_pkg::*;
(
  input  wire logic [A_WIDTH-1:0] a,
  output mult_set_t               multiples
);

  mult_t a1;
  mult_t a2;
  mult_t a4;
  mult_t a8;

  assign a1 = MULT_WIDTH'($signed(a));
  assign a2 = a1 <<< 1;
  assign a4 = a1 <<< 2;
  assign a8 = a1 <<< 3;

  assign multiples[0] = '0;
  assign multiples[1] = a1;
  assign multiples[2] = a2;
  assign multiples[3] = a2 + a1;
  assign multiples[4] = a4;
  assign multiples[5] = a4 + a1;
  assign multiples[6] = a4 + a2;
  assign multiples[7] = a8 - a1;
  assign multiples[8] = a8;

endmodule

`default_nettype wire

[design/rbm_recoder.sv]
// Splits the sign-extended multiplier into overlapping windows and recodes each to a digit.
`timescale 1ns / 1ps
`default_nettype none

module rbm_recoder
  import rbm_pkg::*;
(
  input  wire logic [B_WIDTH-1:0] b,
  output digit_vec_t              digits
);

  logic [EXT_WIDTH-1:0] b_ext;
  logic [EXT_WIDTH:0]   bx;

  assign b_ext = EXT_WIDTH'($signed(b));
  assign bx    = {b_ext, 1'b0};

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      digits[i] = booth_recode(bx[4*i +: 5]);
    end
  end

endmodule

`default_nettype wire

[design/rbm_accumulate.sv]
// Selects one multiple per digit, weights and signs it, and sums the partial products.
`timescale 1ns / 1ps
`default_nettype none

module rbm_accumulate
  import rbm_pkg::*;
(
  input  wire mult_set_t             multiples,
  input  wire digit_vec_t            digits,
  output logic [PROD_WIDTH-1:0]      product
);

  logic [PROD_WIDTH-1:0] terms [DIGITS];

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      terms[i] = '0;
      unique case (digits[i].mag)
        4'd1:    terms[i] = PROD_WIDTH'($signed(multiples[1]));
        4'd2:    terms[i] = PROD_WIDTH'($signed(multiples[2]));
        4'd3:    terms[i] = PROD_WIDTH'($signed(multiples[3]));
        4'd4:    terms[i] = PROD_WIDTH'($signed(multiples[4]));
        4'd5:    terms[i] = PROD_WIDTH'($signed(multiples[5]));
        4'd6:    terms[i] = PROD_WIDTH'($signed(multiples[6]));
        4'd7:    terms[i] = PROD_WIDTH'($signed(multiples[7]));
        4'd8:    terms[i] = PROD_WIDTH'($signed(multiples[8]));
        default: terms[i] = PROD_WIDTH'($signed(multiples[0]));
      endcase
      terms[i] = terms[i] << (4 * i);
      if (digits[i].neg) begin
        terms[i] = ~terms[i] + PROD_WIDTH'(1);
      end
    end
  end

  always_comb begin
    product = '0;
    for (int i = 0; i < DIGITS; i++) begin
      product = product + terms[i];
    end
  end

endmodule

`default_nettype wire

[design/radix16_booth_multiplier_core.sv]
// Top level of the radix-16 Booth multiplier: operand register, Booth datapath, result register.
`timescale 1ns / 1ps
`default_nettype none

// Exact signed multiplier that takes one operand beat per clock while the output is not
// stalled and returns the full 64-bit two's complement product through the operand and
// result registers. Each operand uses only its low 32 bits as a signed value. The operand
// register feeds a single pass of multiple generation, radix-16 Booth recoding and a
// partial-product sum, whose result lands in the result register; those two registers
// set the rate of one beat per cycle. A stalled output holds both stages, and the input
// is ready whenever the operand stage is empty or moving forward.
module radix16_booth_multiplier_core
  import rbm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [IN_WIDTH-1:0]    multiplicand,
  input  wire logic [IN_WIDTH-1:0]    multiplier,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PROD_WIDTH-1:0]       product
);

  logic                  s1_valid;
  logic [A_WIDTH-1:0]    s1_a;
  logic [B_WIDTH-1:0]    s1_b;
  logic                  s1_advance;
  logic                  in_load;
  mult_set_t             multiples;
  digit_vec_t            digits;
  logic [PROD_WIDTH-1:0] product_next;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_load    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_a <= multiplicand[A_WIDTH-1:0];
      s1_b <= multiplier[B_WIDTH-1:0];
    end
    if (s1_advance) begin
      product <= product_next;
    end
  end

  rbm_multiples u_multiples (
    .a         (s1_a),
    .multiples (multiples)
  );

  rbm_recoder u_recoder (
    .b      (s1_b),
    .digits (digits)
  );

  rbm_accumulate u_accumulate (
    .multiples (multiples),
    .digits    (digits),
    .product   (product_next)
  );

  // A full operand stage behind a stalled result must hold off new beats.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input ready while both stages are blocked");

  // An accepted beat always occupies the operand stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_load |=> s1_valid)
    else $error("accepted beat lost from operand stage");

  // A beat leaving the operand stage always shows up as a result.
  assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("operand stage advanced without a result");

  // A zero multiplicand always gives a zero product.
  assert property (@(posedge clk) disable iff (rst)
    (s1_advance && (s1_a == '0)) |=> (product == '0))
    else $error("nonzero product for zero multiplicand");

endmodule

`default_nettype wire

[verif/tb_radix16_booth_multiplier_core.sv]
// Self-checking testbench for the radix-16 Booth multiplier core with random handshake idling.
`timescale 1ns / 1ps

module tb_radix16_booth_multiplier_core;
  import rbm_pkg::*;

  localparam int RANDOM_PAIRS   = 1300;
  localparam int STEADY_FIRST   = 400;
  localparam int STEADY_LAST    = 650;
  localparam int HOLD_AT        = 900;
  localparam int HOLD_CYCLES    = 80;
  localparam int IDLE_PERCENT   = 38;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  class product_scoreboard;
    logic [PROD_WIDTH-1:0] pending_products[$];
    int checked;
    int mismatches;

    function logic [PROD_WIDTH-1:0] booth_product(logic [IN_WIDTH-1:0] x,
                                                  logic [IN_WIDTH-1:0] y);
      logic [63:0] a;
      logic [63:0] b;
      logic [64:0] b_ext;
      logic [63:0] multiple[9];
      logic [63:0] acc;
      logic [63:0] term;
      logic [4:0]  window;
      logic [4:0]  folded;
      logic [4:0]  rounded;
      logic [3:0]  magnitude;
      a = {{(64 - A_WIDTH){x[A_WIDTH-1]}}, x[A_WIDTH-1:0]};
      b = {{(64 - B_WIDTH){y[B_WIDTH-1]}}, y[B_WIDTH-1:0]};
      b_ext = {b, 1'b0};
      multiple[0] = '0;
      multiple[1] = a;
      multiple[2] = a << 1;
      multiple[3] = multiple[2] + a;
      multiple[4] = a << 2;
      multiple[5] = multiple[4] + a;
      multiple[6] = multiple[4] + multiple[2];
      multiple[7] = multiple[4] + multiple[3];
      multiple[8] = a << 3;
      acc = '0;
      for (int i = 0; i < (B_WIDTH + 3) / 4; i++) begin
        window    = b_ext[4*i +: 5];
        folded    = window[4] ? ~window : window;
        rounded   = folded + 5'd1;
        magnitude = rounded[4:1];
        term      = multiple[magnitude] << (4 * i);
        if (window[4]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      return acc;
    endfunction

    function void note_operands(logic [IN_WIDTH-1:0] x, logic [IN_WIDTH-1:0] y);
      pending_products.push_back(booth_product(x, y));
    endfunction

    function void check_product(logic [PROD_WIDTH-1:0] actual);
      logic [PROD_WIDTH-1:0] predicted;
      if (pending_products.size() == 0) begin
        $display("%0t: product beat with none pending, actual %h", $time, actual);
        mismatches++;
      end else begin
        predicted = pending_products.pop_front();
        checked++;
        if (actual !== predicted) begin
          $display("%0t: product mismatch, expected %h, actual %h", $time, predicted, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_WIDTH-1:0]   multiplicand = '0;
  logic [IN_WIDTH-1:0]   multiplier = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PROD_WIDTH-1:0] product;

  product_scoreboard sb = new();
  bit steady = 1'b0;
  int sent = 0;
  int directed_sent = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  radix16_booth_multiplier_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .product      (product)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic offer_operands(input logic [IN_WIDTH-1:0] x, input logic [IN_WIDTH-1:0] y);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    multiplicand <= x;
    multiplier   <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_operands(x, y);
    sent++;
  endtask

  function automatic logic [IN_WIDTH-1:0] random_operand();
    logic [IN_WIDTH-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 32'h0000_0001;
          2: v = '1;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      1: v = 32'($urandom_range(0, 31)) - 32'd16;
      2: begin
        for (int n = 0; n < IN_WIDTH / 4; n++) begin
          case ($urandom_range(0, 3))
            0: v[4*n +: 4] = 4'h0;
            1: v[4*n +: 4] = 4'h7;
            2: v[4*n +: 4] = 4'h8;
            default: v[4*n +: 4] = 4'hF;
          endcase
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_product(product);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("radix16_booth_multiplier_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes, sign corners, all-zero-digit and full-magnitude digit patterns.
    offer_operands(32'h0000_0000, 32'h0000_0000);
    offer_operands(32'h0000_0001, 32'h0000_0001);
    offer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_operands(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_operands(32'h8000_0000, 32'h8000_0000);
    offer_operands(32'h8000_0000, 32'h7FFF_FFFF);
    offer_operands(32'h7FFF_FFFF, 32'h8000_0000);
    offer_operands(32'h8000_0000, 32'hFFFF_FFFF);
    offer_operands(32'hFFFF_FFFF, 32'h8000_0000);
    offer_operands(32'h8000_0000, 32'h0000_0001);
    offer_operands(32'h0000_0000, 32'h8000_0000);
    offer_operands(32'h7FFF_FFFF, 32'h0000_0000);
    offer_operands(32'h0000_3039, 32'h8888_8888);
    offer_operands(32'hFFFF_E19F, 32'h7777_7777);
    offer_operands(32'h5A5A_5A5A, 32'h9999_9999);
    offer_operands(32'h1234_5678, 32'hFFFF_FFFF);
    offer_operands(32'hDEAD_BEEF, 32'h0000_000F);
    offer_operands(32'h7FFF_FFFF, 32'h8000_0001);
    offer_operands(32'hFFFF_0000, 32'h0000_FFFF);
    offer_operands(32'hAAAA_AAAA, 32'h5555_5555);
    offer_operands(32'h5555_5555, 32'hAAAA_AAAA);
    offer_operands(32'h0000_0003, 32'h1000_0000);
    offer_operands(32'h8000_0001, 32'h7FFF_FFF8);
    directed_sent = sent;

    for (int k = 0; k < RANDOM_PAIRS; k++) begin
      steady = (k >= STEADY_FIRST) && (k < STEADY_LAST);
      offer_operands(random_operand(), random_operand());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_products.size() != 0) begin
      $display("%0t: %0d products never arrived", $time, sb.pending_products.size());
      sb.mismatches++;
    end

    $display("Multiplied %0d operand pairs (%0d directed, %0d random), checked %0d products.",
             sent, directed_sent, sent - directed_sent, sb.checked);
    $display("Handshakes idled at random on both sides, with one long output stall.");
    if (sb.mismatches == 0) begin
      $display("radix16_booth_multiplier_core test passed");
    end else begin
      $display("radix16_booth_multiplier_core test failed");
    end
    $finish;
  end

endmodule
